// ===== src/arq_pkg.sv =====
// Shared types and constants for the accumulator requantizer.
package arq_pkg;

    // Scale table geometry
    localparam int CHANNELS  = 256;
    localparam int CH_W      = $clog2(CHANNELS);
    localparam int MULT_W    = 31;
    localparam int SHIFT_W   = 6;
    localparam int ACC_W     = 32;
    localparam int PROD_W    = 62;
    localparam int Q_W       = 8;

    // Queue between front and back
    localparam int JQ_DEPTH  = 4;
    localparam int JQ_PTR_W  = $clog2(JQ_DEPTH);
    localparam int JQ_CNT_W  = $clog2(JQ_DEPTH + 1);

    // Result queue at the back end
    localparam int RQ_DEPTH  = 8;
    localparam int RQ_PTR_W  = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W  = $clog2(RQ_DEPTH + 1);

    // Opcodes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUANT = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_PER_CHANNEL = 2'd0;
    localparam logic [1:0] REG_INT4_MODE   = 2'd1;
    localparam logic [1:0] REG_RELU_MODE   = 2'd2;

    // Clamp bounds as magnitudes
    localparam logic [7:0] INT8_NEG_MAX = 8'd128;
    localparam logic [7:0] INT8_POS_MAX = 8'd127;
    localparam logic [7:0] INT4_NEG_MAX = 8'd8;
    localparam logic [7:0] INT4_POS_MAX = 8'd7;
    localparam logic [7:0] RELU_NEG_MAX = 8'd0;

    typedef struct packed {
        logic per_channel;
        logic int4_mode;
        logic relu_mode;
    } t_cfg;

    typedef struct packed {
        logic                 neg;
        logic [ACC_W-1:0]     mag;
        logic [MULT_W-1:0]    mult;
        logic [SHIFT_W-1:0]   shift;
    } t_job;

    typedef struct packed {
        logic [MULT_W-1:0]    mult;
        logic [SHIFT_W-1:0]   shift;
    } t_scale;

endpackage

// ===== src/arq_front.sv =====
// Front end: item intake, scale table and table read stage.
module arq_front
    import arq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_push,
    output logic                o_full,
    input  logic                i_opcode,
    input  logic [7:0]          i_channel,
    input  logic [ACC_W-1:0]    i_accumulator,
    input  logic [MULT_W-1:0]   i_scale_mult,
    input  logic [SHIFT_W-1:0]  i_scale_shift,
    output logic                o_job_push,
    output t_job                o_job,
    input  logic                i_job_full
);

    t_scale             r_mem [CHANNELS];
    t_scale             r_rd;
    logic               r_f_vld;
    logic               n_f_vld;
    logic               r_f_neg;
    logic [ACC_W-1:0]   r_f_mag;

    logic               accept;
    logic               take_load;
    logic               take_req;
    logic               drain;
    logic [CH_W-1:0]    ch;
    logic [CH_W-1:0]    rd_idx;
    logic               acc_neg;
    logic [ACC_W-1:0]   acc_mag;

    // Stage stays occupied only when it cannot hand off this cycle
    assign drain     = r_f_vld && !i_job_full;
    assign o_full    = r_f_vld && i_job_full;
    assign accept    = i_push && !o_full;
    assign take_load = accept && (i_opcode == OP_LOAD);
    assign take_req  = accept && (i_opcode == OP_REQUANT);

    assign ch      = i_channel[CH_W-1:0];
    assign rd_idx  = i_cfg.per_channel ? ch : '0;
    assign acc_neg = i_accumulator[ACC_W-1];
    assign acc_mag = acc_neg ? (~i_accumulator + 1'b1) : i_accumulator;

    // Write the table on a load, read it on a requantize
    always_ff @(posedge i_clk) begin
        if (take_load) begin
            r_mem[ch] <= '{mult: i_scale_mult, shift: i_scale_shift};
        end
        if (take_req) begin
            r_rd <= r_mem[rd_idx];
        end
    end

    always_comb begin
        n_f_vld = r_f_vld;
        if (take_req) begin
            n_f_vld = 1'b1;
        end else if (drain) begin
            n_f_vld = 1'b0;
        end
    end

    // Hold the accumulator sign and magnitude next to the table data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= n_f_vld;
        end
        if (take_req) begin
            r_f_neg <= acc_neg;
            r_f_mag <= acc_mag;
        end
    end

    assign o_job_push = drain;
    assign o_job      = '{neg: r_f_neg, mag: r_f_mag, mult: r_rd.mult, shift: r_rd.shift};

endmodule

// ===== src/arq_queue.sv =====
// Short job queue between the front and back ends.
module arq_queue
    import arq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_data,
    output logic    o_full,
    input  logic    i_pop,
    output t_job    o_data,
    output logic    o_empty
);

    t_job                   r_mem [JQ_DEPTH];
    logic [JQ_PTR_W-1:0]    r_wr_ptr;
    logic [JQ_PTR_W-1:0]    r_rd_ptr;
    logic [JQ_CNT_W-1:0]    r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = (r_count == JQ_CNT_W'(JQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Store an entry on push
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/arq_back.sv =====
// Back end: multiply, round half to even, clamp and result queue.
module arq_back
    import arq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_job_empty,
    input  t_job                i_job,
    output logic                o_job_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic signed [Q_W-1:0] o_q_value,
    output logic                o_clipped
);

    // Multiply stage
    logic                   r_m_vld;
    logic                   r_m_neg;
    logic [PROD_W-1:0]      r_m_prod;
    logic [SHIFT_W-1:0]     r_m_shift;
    // Round stage
    logic                   r_r_vld;
    logic                   r_r_neg;
    logic [PROD_W-1:0]      r_r_q;
    logic                   r_r_up;
    // Clamp stage
    logic                   r_c_vld;
    logic [Q_W-1:0]         r_c_val;
    logic                   r_c_clip;
    // Result queue
    logic [Q_W:0]           r_rq [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]    r_wr_ptr;
    logic [RQ_PTR_W-1:0]    r_rd_ptr;
    logic [RQ_CNT_W-1:0]    r_count;

    logic                   take;
    logic [RQ_CNT_W:0]      used;
    logic [ACC_W+MULT_W-1:0] prod;
    logic [63:0]            p64;
    logic [63:0]            q64;
    logic [63:0]            low_mask;
    logic [SHIFT_W-1:0]     sh_m1;
    logic                   guard;
    logic                   sticky;
    logic [PROD_W:0]        qr;
    logic                   big;
    logic [7:0]             neg_max;
    logic [7:0]             pos_max;
    logic [Q_W-1:0]         n_val;
    logic                   n_clip;
    logic                   rq_pop;

    // Take a job only when the result queue has room for everything in flight
    assign used = (RQ_CNT_W+1)'(r_count) + (RQ_CNT_W+1)'(r_m_vld)
                + (RQ_CNT_W+1)'(r_r_vld) + (RQ_CNT_W+1)'(r_c_vld);
    assign take      = !i_job_empty && (used < (RQ_CNT_W+1)'(RQ_DEPTH));
    assign o_job_pop = take;

    assign prod = i_job.mag * i_job.mult;

    // Split the product at the shift point
    always_comb begin
        p64      = {{(64-PROD_W){1'b0}}, r_m_prod};
        q64      = p64 >> r_m_shift;
        sh_m1    = r_m_shift - 1'b1;
        low_mask = ~({64{1'b1}} << sh_m1);
        guard    = (r_m_shift != '0) && p64[sh_m1];
        sticky   = (r_m_shift != '0) && ((p64 & low_mask) != '0);
    end

    // Round, then clamp to the active range
    always_comb begin
        qr = (PROD_W+1)'(r_r_q) + (PROD_W+1)'(r_r_up);
        big = |qr[PROD_W:8];
        if (i_cfg.int4_mode) begin
            neg_max = INT4_NEG_MAX;
            pos_max = INT4_POS_MAX;
        end else if (i_cfg.relu_mode) begin
            neg_max = RELU_NEG_MAX;
            pos_max = INT8_POS_MAX;
        end else begin
            neg_max = INT8_NEG_MAX;
            pos_max = INT8_POS_MAX;
        end
        n_clip = 1'b0;
        if (r_r_neg && (qr != '0)) begin
            if (big || (qr[7:0] > neg_max)) begin
                n_clip = 1'b1;
                n_val  = Q_W'(8'd0 - neg_max);
            end else begin
                n_val  = Q_W'(8'd0 - qr[7:0]);
            end
        end else begin
            if (big || (qr[7:0] > pos_max)) begin
                n_clip = 1'b1;
                n_val  = Q_W'(pos_max);
            end else begin
                n_val  = Q_W'(qr[7:0]);
            end
        end
    end

    // Advance the pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_r_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_m_vld <= take;
            r_r_vld <= r_m_vld;
            r_c_vld <= r_r_vld;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_m_neg   <= i_job.neg;
            r_m_prod  <= prod[PROD_W-1:0];
            r_m_shift <= i_job.shift;
        end
        if (r_m_vld) begin
            r_r_neg <= r_m_neg;
            r_r_q   <= q64[PROD_W-1:0];
            r_r_up  <= guard && (sticky || q64[0]);
        end
        if (r_r_vld) begin
            r_c_val  <= n_val;
            r_c_clip <= n_clip;
        end
    end

    // Result queue
    assign o_empty   = (r_count == '0);
    assign rq_pop    = i_pop && !o_empty;
    assign o_q_value = r_rq[r_rd_ptr][Q_W:1];
    assign o_clipped = r_rq[r_rd_ptr][0];

    always_ff @(posedge i_clk) begin
        if (r_c_vld) begin
            r_rq[r_wr_ptr] <= {r_c_val, r_c_clip};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (r_c_vld) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rq_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (r_c_vld && !rq_pop) begin
                r_count <= r_count + 1'b1;
            end else if (rq_pop && !r_c_vld) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/accumulator_requantizer.sv =====
// A requantize item passes the front read stage, job queue, multiply, round and clamp stages
// and the result queue before it shows on the result side. Throughput: one item per cycle
// while the job and result queues have room, set by the table read port and the three-stage
// multiply, round and clamp pipeline behind a 4-entry job queue. Load items write the scale
// table and produce no result. Reset (synchronous, active low) clears config registers,
// queues and valids; the scale table is not cleared and must be loaded before use.
module accumulator_requantizer
    import arq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic                    i_cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic                    i_opcode,
    input  logic [7:0]              i_channel,
    input  logic signed [ACC_W-1:0] i_accumulator,
    input  logic [MULT_W-1:0]       i_scale_mult,
    input  logic [SHIFT_W-1:0]      i_scale_shift,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [Q_W-1:0]   o_q_value,
    output logic                    o_clipped
);

    t_cfg   r_cfg;
    logic   job_push;
    t_job   job_in;
    logic   job_full;
    logic   job_pop;
    t_job   job_out;
    logic   job_empty;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PER_CHANNEL: r_cfg.per_channel <= i_cfg_data;
                REG_INT4_MODE:   r_cfg.int4_mode   <= i_cfg_data;
                REG_RELU_MODE:   r_cfg.relu_mode   <= i_cfg_data;
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    arq_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_push        (push),
        .o_full        (full),
        .i_opcode      (i_opcode),
        .i_channel     (i_channel),
        .i_accumulator (i_accumulator),
        .i_scale_mult  (i_scale_mult),
        .i_scale_shift (i_scale_shift),
        .o_job_push    (job_push),
        .o_job         (job_in),
        .i_job_full    (job_full)
    );

    arq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    arq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_q_value   (o_q_value),
        .o_clipped   (o_clipped)
    );

endmodule

// ===== verif/accumulator_requantizer_tb.sv =====
// Self-checking testbench for the accumulator requantizer with a scoreboard prediction.
module accumulator_requantizer_tb;
    import arq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         SETTLE_CYCLES = 10;
    localparam int         DRAIN_CYCLES  = 12;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         PHASE_ITEMS   = 115;
    localparam logic [1:0] REG_SPARE     = 2'd3;

    // One quantized result as the block presents it
    typedef struct packed {
        logic signed [Q_W-1:0] value;
        logic                  clipped;
    } t_quant;

    // Tracks the scale table and mode, predicts each requantize result
    class quant_board;
        logic [MULT_W-1:0]  mult_tab[CHANNELS];
        logic [SHIFT_W-1:0] shift_tab[CHANNELS];
        t_cfg               cfg;
        t_quant             quant_due[$];
        int                 errors;

        function new();
            cfg    = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic data);
            case (idx)
                REG_PER_CHANNEL: cfg.per_channel = data;
                REG_INT4_MODE:   cfg.int4_mode = data;
                REG_RELU_MODE:   cfg.relu_mode = data;
                default: ;
            endcase
        endfunction

        // Exact product, shift with round half to even, clamp to the active range
        function t_quant requantize(logic [ACC_W-1:0] acc, logic [MULT_W-1:0] mult,
                                    logic [SHIFT_W-1:0] sh);
            logic [63:0] mag;
            logic [63:0] prod;
            logic [63:0] rem;
            logic [63:0] half;
            logic [63:0] q;
            logic [7:0]  neg_lim;
            logic [7:0]  pos_lim;
            t_quant      r;
            mag  = acc[ACC_W-1] ? 64'd0 - {{32{1'b1}}, acc} : {32'd0, acc};
            prod = mag * {33'd0, mult};
            q    = prod >> sh;
            if (sh != 0) begin
                rem  = prod & ((64'd1 << sh) - 64'd1);
                half = 64'd1 << (sh - 1);
                if (rem > half || (rem == half && q[0]))
                    q = q + 64'd1;
            end
            if (cfg.int4_mode) begin
                neg_lim = INT4_NEG_MAX;
                pos_lim = INT4_POS_MAX;
            end else if (cfg.relu_mode) begin
                neg_lim = RELU_NEG_MAX;
                pos_lim = INT8_POS_MAX;
            end else begin
                neg_lim = INT8_NEG_MAX;
                pos_lim = INT8_POS_MAX;
            end
            r.clipped = 1'b0;
            if (acc[ACC_W-1] && q != 64'd0) begin
                if (q > {56'd0, neg_lim}) begin
                    q         = {56'd0, neg_lim};
                    r.clipped = 1'b1;
                end
                r.value = 8'd0 - q[7:0];
            end else begin
                if (q > {56'd0, pos_lim}) begin
                    q         = {56'd0, pos_lim};
                    r.clipped = 1'b1;
                end
                r.value = q[7:0];
            end
            return r;
        endfunction

        function void note_item(logic op, logic [7:0] ch, logic [ACC_W-1:0] acc,
                                logic [MULT_W-1:0] mult, logic [SHIFT_W-1:0] sh);
            int idx;
            if (op == OP_LOAD) begin
                mult_tab[ch]  = mult;
                shift_tab[ch] = sh;
            end else begin
                idx = cfg.per_channel ? int'(ch) : 0;
                quant_due.push_back(requantize(acc, mult_tab[idx], shift_tab[idx]));
            end
        endfunction

        function void check_quant(logic signed [Q_W-1:0] value, logic clipped);
            t_quant want;
            if (quant_due.size() == 0) begin
                $display("%0t: unexpected result q_value %0d clipped %0b",
                         $time, value, clipped);
                errors++;
                return;
            end
            want = quant_due.pop_front();
            if (value !== want.value) begin
                $display("%0t: q_value mismatch: expected %0d, actual %0d",
                         $time, want.value, value);
                errors++;
            end
            if (clipped !== want.clipped) begin
                $display("%0t: clipped mismatch: expected %0b, actual %0b",
                         $time, want.clipped, clipped);
                errors++;
            end
        endfunction

        function int pending();
            return quant_due.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [1:0]              i_cfg_index;
    logic                    i_cfg_data;
    logic                    push;
    logic                    full;
    logic                    i_opcode;
    logic [7:0]              i_channel;
    logic signed [ACC_W-1:0] i_accumulator;
    logic [MULT_W-1:0]       i_scale_mult;
    logic [SHIFT_W-1:0]      i_scale_shift;
    logic                    empty;
    logic                    pop = 1'b0;
    logic signed [Q_W-1:0]   o_q_value;
    logic                    o_clipped;

    quant_board board = new();
    logic       steady;
    logic       loaded[CHANNELS];
    logic       per_channel_on;
    int         stall_count = 0;

    accumulator_requantizer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_opcode      (i_opcode),
        .i_channel     (i_channel),
        .i_accumulator (i_accumulator),
        .i_scale_mult  (i_scale_mult),
        .i_scale_shift (i_scale_shift),
        .empty         (empty),
        .pop           (pop),
        .o_q_value     (o_q_value),
        .o_clipped     (o_clipped)
    );

    always #5 i_clk = ~i_clk;

    // Record register writes and input transfers, check result transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                board.write_reg(i_cfg_index, i_cfg_data);
            if (push && !full)
                board.note_item(i_opcode, i_channel, i_accumulator, i_scale_mult,
                                i_scale_shift);
            if (pop && !empty)
                board.check_quant(o_q_value, o_clipped);
        end
    end

    // Stall the result side at random, except in a steady stretch
    always @(posedge i_clk) begin
        pop <= steady ? 1'b1 : ($urandom_range(99) >= 20);
    end

    // End the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Present one item and hold it until the transfer
    task automatic send_item(logic op, logic [7:0] ch, logic [ACC_W-1:0] acc,
                             logic [MULT_W-1:0] mult, logic [SHIFT_W-1:0] sh);
        if (!steady && $urandom_range(99) < 20) begin
            push <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_opcode      <= op;
        i_channel     <= ch;
        i_accumulator <= acc;
        i_scale_mult  <= mult;
        i_scale_shift <= sh;
        do
            @(posedge i_clk);
        while (full);
        if (op == OP_LOAD)
            loaded[ch] = 1'b1;
    endtask

    // Drain the block, then write every register including the unused index
    task automatic set_mode(logic pc, logic i4, logic relu);
        push <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_PER_CHANNEL;
        i_cfg_data  <= pc;
        @(posedge i_clk);
        i_cfg_index <= REG_INT4_MODE;
        i_cfg_data  <= i4;
        @(posedge i_clk);
        i_cfg_index <= REG_RELU_MODE;
        i_cfg_data  <= relu;
        @(posedge i_clk);
        i_cfg_index <= REG_SPARE;
        i_cfg_data  <= 1'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        per_channel_on = pc;
    endtask

    function automatic logic [ACC_W-1:0] pick_accumulator();
        logic [ACC_W-1:0] corner[5];
        corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1};
        case ($urandom_range(9))
            0:             return corner[$urandom_range(4)];
            1, 2, 3, 4, 5, 6: return $signed($urandom) >>> $urandom_range(31);
            default:       return $urandom;
        endcase
    endfunction

    // Random loads and requantizes; only loaded entries are ever read
    task automatic random_phase(int count);
        logic [7:0]         ch;
        logic [MULT_W-1:0]  mult;
        logic [SHIFT_W-1:0] sh;
        repeat (count) begin
            ch   = 8'($urandom_range(255));
            mult = MULT_W'($urandom >> $urandom_range(31, 1));
            sh   = ($urandom_range(99) < 40) ? SHIFT_W'($urandom_range(63))
                                             : SHIFT_W'($urandom_range(56, 20));
            if ($urandom_range(99) < 15 || (per_channel_on && !loaded[ch]))
                send_item(OP_LOAD, ch, $urandom, mult, sh);
            else
                send_item(OP_REQUANT, ch, pick_accumulator(), mult, sh);
        end
    endtask

    initial begin
        t_cfg modes[8];
        modes = '{3'b000, 3'b100, 3'b010, 3'b001, 3'b111, 3'b101, 3'b011, 3'b110};
        foreach (loaded[k])
            loaded[k] = 1'b0;
        per_channel_on = 1'b0;
        steady        <= 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_PER_CHANNEL;
        i_cfg_data    <= 1'b0;
        push          <= 1'b0;
        i_opcode      <= OP_LOAD;
        i_channel     <= '0;
        i_accumulator <= '0;
        i_scale_mult  <= '0;
        i_scale_shift <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Tensor mode, int8: zero shift with clamp edges
        set_mode(1'b0, 1'b0, 1'b0);
        send_item(OP_LOAD, 8'd0, '0, 31'd1, 6'd0);
        send_item(OP_REQUANT, 8'd7, 32'd127, '0, '0);
        send_item(OP_REQUANT, 8'd7, 32'd128, '0, '0);
        send_item(OP_REQUANT, 8'd7, -32'sd128, '0, '0);
        send_item(OP_REQUANT, 8'd7, -32'sd129, '0, '0);
        send_item(OP_REQUANT, 8'd7, 32'h7fff_ffff, '0, '0);
        send_item(OP_REQUANT, 8'd7, 32'h8000_0000, '0, '0);
        // Ties go to the even neighbor, both signs
        send_item(OP_LOAD, 8'd0, '0, 31'd1, 6'd1);
        send_item(OP_REQUANT, 8'd0, 32'd5, '0, '0);
        send_item(OP_REQUANT, 8'd0, 32'd7, '0, '0);
        send_item(OP_REQUANT, 8'd0, -32'sd5, '0, '0);
        send_item(OP_REQUANT, 8'd0, -32'sd3, '0, '0);
        // Largest multiplier with the deepest shifts
        send_item(OP_LOAD, 8'd0, '0, 31'h7fff_ffff, 6'd63);
        send_item(OP_REQUANT, 8'd0, 32'h8000_0000, '0, '0);
        send_item(OP_LOAD, 8'd0, '0, 31'h7fff_ffff, 6'd62);
        send_item(OP_REQUANT, 8'd0, 32'h8000_0000, '0, '0);
        send_item(OP_REQUANT, 8'd0, 32'h7fff_ffff, '0, '0);
        // Top channel entry, then a zero multiplier
        send_item(OP_LOAD, 8'd255, '0, 31'd3, 6'd2);
        send_item(OP_LOAD, 8'd0, '0, 31'd0, 6'd5);
        send_item(OP_REQUANT, 8'd0, -32'sd1, '0, '0);

        // Per-channel read of the top entry with ties
        set_mode(1'b1, 1'b0, 1'b0);
        send_item(OP_REQUANT, 8'd255, 32'd2, '0, '0);
        send_item(OP_REQUANT, 8'd255, -32'sd2, '0, '0);

        // Random phases over every mode combination
        foreach (modes[p]) begin
            set_mode(modes[p].per_channel, modes[p].int4_mode, modes[p].relu_mode);
            steady <= (p == 2);
            random_phase(PHASE_ITEMS);
        end

        push   <= 1'b0;
        steady <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
